// ===== design/s3mpu_pkg.sv =====
// Shared types, constants and byte-mapping functions for the packed pattern unpacker.
// No dependencies; used by s3mpu_parser and s3m_pattern_unpacker_unit.
`default_nettype none

package s3mpu_pkg;

  localparam int ROWS         = 64;
  localparam int MAX_CHANNELS = 32;

  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int CHAN_W  = 5;
  localparam int NUM_CH_W = 6;
  localparam int CNT_W   = 16;
  localparam int TDATA_IN_W  = 8;
  localparam int TUSER_IN_W  = 2;
  localparam int TDATA_OUT_W = 88;
  localparam int TUSER_OUT_W = 1;
  localparam int ADDR_W  = 3;
  localparam int APB_W   = 32;

  localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = 6'd4;

  // register index, decoded from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_NUM_CHANNELS = 1'b0;

  localparam logic [4:0] CMD_NONE  = 5'd0;
  localparam logic [4:0] CMD_BREAK = 5'd3;
  localparam logic [4:0] CMD_Z     = 5'd26;

  localparam logic [1:0] VK_NONE = 2'd0;
  localparam logic [1:0] VK_VOL  = 2'd1;
  localparam logic [1:0] VK_PAN  = 2'd2;

  typedef enum logic [6:0] {
    PH_MASK  = 7'b0000001,
    PH_NOTE  = 7'b0000010,
    PH_INSTR = 7'b0000100,
    PH_VOL   = 7'b0001000,
    PH_CMD   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
  } vol_t;

  typedef struct packed {
    logic [5:0]       row;
    logic [CHAN_W-1:0] channel;
    logic [7:0]       note;
    logic [7:0]       instrument;
    logic [1:0]       vol_kind;
    logic [6:0]       volume;
    logic [4:0]       command;
    logic [7:0]       param;
    logic             pattern_done;
    logic [CNT_W-1:0] zxx_left_count;
    logic [CNT_W-1:0] zxx_right_count;
    logic             zxx_high_seen;
  } cell_t;

  function automatic logic [7:0] note_map(input logic [7:0] b);
    logic [7:0] n;
    if (b < 8'hF0) begin
      n = {4'b0, b[3:0]} + ({4'b0, b[7:4]} * 8'd12) + 8'd13;
    end else if (b == 8'hFF) begin
      n = 8'd0;
    end else begin
      n = b;
    end
    return n;
  endfunction

  function automatic vol_t vol_map(input logic [7:0] b);
    vol_t v;
    if (b >= 8'd128 && b <= 8'd192) begin
      v.kind  = VK_PAN;
      v.value = 7'(b - 8'd128);
    end else begin
      v.kind  = VK_VOL;
      v.value = (b > 8'd64) ? 7'd64 : b[6:0];
    end
    return v;
  endfunction

  function automatic logic [4:0] cmd_map(input logic [7:0] b);
    logic [7:0] c;
    logic [4:0] r;
    c = b | 8'h40;
    if (b != 8'd0 && c >= 8'h41 && c <= 8'h5D) begin
      r = c[4:0];
    end else begin
      r = CMD_NONE;
    end
    return r;
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] p);
    return ({4'b0, p[7:4]} * 8'd10) + {4'b0, p[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/s3mpu_parser.sv =====
// Byte-level parse state machine: row tracking, cell decode, Z statistics.
// Depends on s3mpu_pkg. Result is combinational from state and the accepted beat.
`default_nettype none

module s3mpu_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          beat,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          pattern_start,
  input  wire logic                          module_start,
  input  wire logic [s3mpu_pkg::NUM_CH_W-1:0] num_channels,
  output logic                               res_valid,
  output s3mpu_pkg::cell_t                   res
);

  s3mpu_pkg::phase_t                   phase, phase_next;
  logic [s3mpu_pkg::ROW_W-1:0]         row_count, row_count_next;
  logic [7:0]                          mask, mask_next;
  logic                                skip_cell, skip_cell_next;
  logic [7:0]                          note_hold, note_hold_next;
  logic [7:0]                          instr_hold, instr_hold_next;
  s3mpu_pkg::vol_t                     vol_hold, vol_hold_next;
  logic [4:0]                          cmd_hold, cmd_hold_next;
  logic [s3mpu_pkg::CNT_W-1:0]         left_count, left_count_next;
  logic [s3mpu_pkg::CNT_W-1:0]         right_count, right_count_next;
  logic                                high_flag, high_flag_next;

  always_comb begin
    s3mpu_pkg::phase_t           ph;
    logic                        fin;
    logic                        done;
    logic [7:0]                  fin_param;
    logic [s3mpu_pkg::CHAN_W-1:0] chn;

    ph               = pattern_start ? s3mpu_pkg::PH_MASK : phase;
    row_count_next   = pattern_start ? '0 : row_count;
    left_count_next  = module_start ? '0 : left_count;
    right_count_next = module_start ? '0 : right_count;
    high_flag_next   = module_start ? 1'b0 : high_flag;
    phase_next       = ph;
    mask_next        = mask;
    skip_cell_next   = skip_cell;
    note_hold_next   = note_hold;
    instr_hold_next  = instr_hold;
    vol_hold_next    = vol_hold;
    cmd_hold_next    = cmd_hold;
    fin              = 1'b0;
    done             = 1'b0;
    fin_param        = 8'd0;
    chn              = data_byte[s3mpu_pkg::CHAN_W-1:0];

    unique case (ph)
      s3mpu_pkg::PH_MASK: begin
        if (data_byte == 8'd0) begin
          row_count_next = row_count_next + 1'b1;
          if (row_count_next >= s3mpu_pkg::ROW_W'(s3mpu_pkg::ROWS)) begin
            phase_next = s3mpu_pkg::PH_DONE;
            done       = 1'b1;
          end
        end else begin
          mask_next       = data_byte;
          skip_cell_next  = !(({1'b0, chn} < num_channels) &&
                              (32'(chn) < s3mpu_pkg::MAX_CHANNELS));
          note_hold_next  = 8'd0;
          instr_hold_next = 8'd0;
          vol_hold_next   = '0;
          cmd_hold_next   = s3mpu_pkg::CMD_NONE;
          priority if (data_byte[5]) phase_next = s3mpu_pkg::PH_NOTE;
          else if (data_byte[6])     phase_next = s3mpu_pkg::PH_VOL;
          else if (data_byte[7])     phase_next = s3mpu_pkg::PH_CMD;
          else                       phase_next = s3mpu_pkg::PH_MASK;
        end
      end
      s3mpu_pkg::PH_NOTE: begin
        note_hold_next = s3mpu_pkg::note_map(data_byte);
        phase_next     = s3mpu_pkg::PH_INSTR;
      end
      s3mpu_pkg::PH_INSTR: begin
        instr_hold_next = data_byte;
        priority if (mask[6]) phase_next = s3mpu_pkg::PH_VOL;
        else if (mask[7])     phase_next = s3mpu_pkg::PH_CMD;
        else                  fin = 1'b1;
      end
      s3mpu_pkg::PH_VOL: begin
        vol_hold_next = s3mpu_pkg::vol_map(data_byte);
        if (mask[7]) phase_next = s3mpu_pkg::PH_CMD;
        else         fin = 1'b1;
      end
      s3mpu_pkg::PH_CMD: begin
        cmd_hold_next = s3mpu_pkg::cmd_map(data_byte);
        phase_next    = s3mpu_pkg::PH_PARAM;
      end
      s3mpu_pkg::PH_PARAM: begin
        fin       = 1'b1;
        fin_param = data_byte;
      end
      s3mpu_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (fin) begin
      phase_next = s3mpu_pkg::PH_MASK;
      if (!skip_cell_next) begin
        if (cmd_hold_next == s3mpu_pkg::CMD_BREAK) fin_param = s3mpu_pkg::bcd_to_bin(fin_param);
        if (cmd_hold_next == s3mpu_pkg::CMD_Z) begin
          priority if (fin_param > 8'h0F) begin
            high_flag_next = 1'b1;
          end else if (fin_param < 8'h08) begin
            if (left_count_next != '1) left_count_next = left_count_next + 1'b1;
          end else if (fin_param > 8'h08) begin
            if (right_count_next != '1) right_count_next = right_count_next + 1'b1;
          end else begin
          end
        end
      end
    end

    res_valid = beat && (done || (fin && !skip_cell_next));

    res                 = '0;
    res.zxx_left_count  = left_count_next;
    res.zxx_right_count = right_count_next;
    res.zxx_high_seen   = high_flag_next;
    if (done) begin
      res.pattern_done = 1'b1;
    end else begin
      res.row        = row_count_next[5:0];
      res.channel    = mask_next[s3mpu_pkg::CHAN_W-1:0];
      res.note       = note_hold_next;
      res.instrument = instr_hold_next;
      res.vol_kind   = vol_hold_next.kind;
      res.volume     = vol_hold_next.value;
      res.command    = cmd_hold_next;
      res.param      = fin_param;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= s3mpu_pkg::PH_MASK;
      row_count   <= '0;
      mask        <= '0;
      skip_cell   <= 1'b0;
      note_hold   <= '0;
      instr_hold  <= '0;
      vol_hold    <= '0;
      cmd_hold    <= '0;
      left_count  <= '0;
      right_count <= '0;
      high_flag   <= 1'b0;
    end else if (beat) begin
      phase       <= phase_next;
      row_count   <= row_count_next;
      mask        <= mask_next;
      skip_cell   <= skip_cell_next;
      note_hold   <= note_hold_next;
      instr_hold  <= instr_hold_next;
      vol_hold    <= vol_hold_next;
      cmd_hold    <= cmd_hold_next;
      left_count  <= left_count_next;
      right_count <= right_count_next;
      high_flag   <= high_flag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("parse phase not one-hot");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= s3mpu_pkg::ROW_W'(s3mpu_pkg::ROWS))
    else $error("row count past end of pattern");

  a_left_monotonic: assert property (@(posedge clk) disable iff (rst)
    beat && !module_start |=> left_count >= $past(left_count))
    else $error("left Z count went down without clear");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.pattern_done |=> phase == s3mpu_pkg::PH_DONE)
    else $error("end of pattern reported without entering done");
`endif

endmodule

`default_nettype wire

// ===== design/s3m_pattern_unpacker_unit.sv =====
// Packed pattern unpacker top level: APB register, parser, two-entry output buffer.
// Depends on s3mpu_pkg and s3mpu_parser.
//
// Usage:
//   Slave stream takes one packed pattern byte per beat in s_tdata; s_tuser carries
//   pattern_start (bit 0, restarts row and parser) and module_start (bit 1, clears Z stats).
//   Master stream gives one decoded cell per beat; m_tuser[0] is pattern_done.
//   num_channels is written over APB at byte address 0 while the block is idle.
// Output: a finished cell is registered into the output buffer and then shown on m_tvalid.
// Throughput: one byte per cycle while s_tready is high; parse state updates on each accepted byte.
// Bytes that finish no cell (masks, row ends, held fields) produce no beat.
// Reset: num_channels = 4, parser waits for a mask byte at row 0, stats cleared,
//   output buffer empty.
// Stall: results go to a two-entry output buffer; s_tready is low only while both
//   entries are full, so input keeps flowing while one result waits.
`default_nettype none

module s3m_pattern_unpacker_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [s3mpu_pkg::TDATA_IN_W-1:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [s3mpu_pkg::TUSER_IN_W-1:0]  s_tuser,   // [0] pattern_start, [1] module_start
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [5:0] row, [10:6] channel, [18:11] note, [26:19] instrument, [28:27] vol_kind,
  // [35:29] volume, [40:36] command, [48:41] param, [64:49] zxx_left_count,
  // [80:65] zxx_right_count, [81] zxx_high_seen, [87:82] zero
  output logic [s3mpu_pkg::TDATA_OUT_W-1:0]      m_tdata,
  output logic [s3mpu_pkg::TUSER_OUT_W-1:0]      m_tuser,   // [0] pattern_done
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [s3mpu_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [s3mpu_pkg::APB_W-1:0]       pwdata,
  output logic [s3mpu_pkg::APB_W-1:0]            prdata,
  output logic                                  pready
);

  logic [s3mpu_pkg::NUM_CH_W-1:0] num_channels;
  logic                           reg_sel;
  logic                           beat;
  logic                           res_valid;
  s3mpu_pkg::cell_t               res;
  logic                           main_valid, skid_valid;
  s3mpu_pkg::cell_t               main_cell, skid_cell;
  logic                           pop;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[s3mpu_pkg::ADDR_W-1:2] == s3mpu_pkg::REG_NUM_CHANNELS);
  assign prdata  = reg_sel ? {{(s3mpu_pkg::APB_W-s3mpu_pkg::NUM_CH_W){1'b0}}, num_channels}
                           : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= s3mpu_pkg::NUM_CH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      num_channels <= pwdata[s3mpu_pkg::NUM_CH_W-1:0];
    end
  end

  assign s_tready = !skid_valid;
  assign beat     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  s3mpu_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .data_byte     (s_tdata[7:0]),
    .pattern_start (s_tuser[0]),
    .module_start  (s_tuser[1]),
    .num_channels  (num_channels),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !main_valid) begin
      main_cell <= skid_valid ? skid_cell : res;
    end else if (res_valid) begin
      skid_cell <= res;
    end
  end

  assign m_tvalid = main_valid;
  assign m_tuser  = main_cell.pattern_done;
  assign m_tdata  = {6'b0,
                     main_cell.zxx_high_seen,
                     main_cell.zxx_right_count,
                     main_cell.zxx_left_count,
                     main_cell.param,
                     main_cell.command,
                     main_cell.volume,
                     main_cell.vol_kind,
                     main_cell.instrument,
                     main_cell.note,
                     main_cell.channel,
                     main_cell.row};

`ifndef NO_ASSERTIONS
  a_skid_order: assert property (@(posedge clk) disable iff (rst) skid_valid |-> main_valid)
    else $error("skid entry held with empty main entry");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !pop |=> skid_valid && $stable(skid_cell))
    else $error("skid entry lost while stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    main_valid && !skid_valid && pop && !res_valid |=> !main_valid)
    else $error("output beat repeated");
`endif

endmodule

`default_nettype wire
